### design/tlsf_pkg.sv
// Shared types, constants and bit-scan helpers of the segregated fit allocator.
// No dependencies; used by tlsf_class, tlsf_bitmap and the top level.
package tlsf_pkg;

  localparam int unsigned PoolBytes    = 65536;
  localparam int unsigned GranuleBytes = 8;
  localparam int unsigned HeaderBytes  = 32;
  localparam int unsigned MinBlock     = 32;
  localparam int unsigned SlBits       = 4;
  localparam int unsigned FlClasses    = 32;
  localparam int unsigned SmallLimit   = 128;

  localparam int unsigned Granules   = PoolBytes / GranuleBytes;
  localparam int unsigned GW         = $clog2(Granules);        // granule index width
  localparam int unsigned LW         = GW + 1;                  // link width, NIL included
  localparam int unsigned FlW        = $clog2(FlClasses);
  localparam int unsigned L2Count    = 1 << SlBits;
  localparam int unsigned ClassCount = FlClasses * L2Count;
  localparam int unsigned CW         = $clog2(ClassCount);
  localparam int unsigned HdrGran    = HeaderBytes / GranuleBytes;
  localparam int unsigned BigBytes   = ((PoolBytes - 3 * HeaderBytes) / GranuleBytes)
                                       * GranuleBytes;
  localparam int unsigned TailGran   = HdrGran + HdrGran + BigBytes / GranuleBytes;

  localparam logic [LW-1:0] Nil = LW'(Granules);

  // request actions
  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  // result status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNoFit = 2'd1;
  localparam logic [1:0] StZero  = 2'd2;

  // block header as stored in the header memory
  typedef struct packed {
    logic        valid;
    logic        free;
    logic        pfree;
    logic [15:0] size;
  } hdr_t;

  typedef struct packed {
    logic [FlW-1:0]    fl;
    logic [SlBits-1:0] sl;
    logic [4:0]        tb;
  } cls_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [FlW-1:0]    fl;
    logic [SlBits-1:0] sl;
  } bm_cmd_t;

  function automatic logic [4:0] top_bit17(input logic [16:0] w);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 17; i++) begin
      if (w[i]) r = 5'(i);
    end
    return r;
  endfunction

  function automatic logic [SlBits-1:0] low_bit16(input logic [L2Count-1:0] w);
    logic [SlBits-1:0] r;
    r = '0;
    for (int i = L2Count - 1; i >= 0; i--) begin
      if (w[i]) r = SlBits'(i);
    end
    return r;
  endfunction

  function automatic logic [FlW-1:0] low_bit32(input logic [FlClasses-1:0] w);
    logic [FlW-1:0] r;
    r = '0;
    for (int i = FlClasses - 1; i >= 0; i--) begin
      if (w[i]) r = FlW'(i);
    end
    return r;
  endfunction

endpackage

### design/two_level_segregated_fit_allocator.sv
// Top level of the two-level segregated fit allocator: sequencer and header memories.
// Depends on tlsf_pkg, tlsf_class and tlsf_bitmap.
//
// Usage: raise start_i with action_i (0 allocate, 1 free) and the request fields
// while busy_o is low; the request is taken on that edge. Exactly one result comes
// back later on payload_offset_o / status_o, marked by done_o for one cycle; the
// receiver cannot stall it, so capture it when done_o is high. A new request may
// be issued in the same cycle that done_o is shown. After reset the block runs a
// clearing pass over the 8192-entry header memory and then lays out the pool with
// busy_o high. Each header/link/list-head memory has one write port and one
// registered read port, so reads that depend on each other take separate steps. An
// allocate rounds the size up to a class, searches the bitmaps (moving to a higher
// first-level class if needed), reads the list head and header, unlinks the block
// and either splits it, linking the free remainder, or takes the whole block; it
// ends when no class fits or the size is zero. A free ignores a misaligned offset
// or a block that the header check rejects; otherwise it unlinks and merges each
// free neighbor, rewrites the headers and links the merged block at the head of
// its list.
module two_level_segregated_fit_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] free_offset_i,
  output logic        done_o,
  output logic [15:0] payload_offset_o,
  output logic [1:0]  status_o
);

  localparam int unsigned GW = tlsf_pkg::GW;
  localparam int unsigned LW = tlsf_pkg::LW;
  localparam int unsigned CW = tlsf_pkg::CW;

  typedef enum logic [29:0] {
    S_IDLE    = 30'd1 << 0,
    S_CLEAR   = 30'd1 << 1,
    S_INIT0   = 30'd1 << 2,
    S_INIT1   = 30'd1 << 3,
    S_INIT2   = 30'd1 << 4,
    S_AROUND  = 30'd1 << 5,
    S_ACLASS  = 30'd1 << 6,
    S_ASRCH2  = 30'd1 << 7,
    S_AHEAD   = 30'd1 << 8,
    S_AHDR    = 30'd1 << 9,
    S_ASPLIT  = 30'd1 << 10,
    S_AS1     = 30'd1 << 11,
    S_AS2     = 30'd1 << 12,
    S_AN1     = 30'd1 << 13,
    S_FCHK    = 30'd1 << 14,
    S_FP0     = 30'd1 << 15,
    S_FP1     = 30'd1 << 16,
    S_FP2     = 30'd1 << 17,
    S_FP3     = 30'd1 << 18,
    S_FNXT    = 30'd1 << 19,
    S_FN1     = 30'd1 << 20,
    S_FN2     = 30'd1 << 21,
    S_FN3     = 30'd1 << 22,
    S_FN4     = 30'd1 << 23,
    S_U0      = 30'd1 << 24,
    S_U1      = 30'd1 << 25,
    S_L0      = 30'd1 << 26,
    S_L1      = 30'd1 << 27,
    S_L2      = 30'd1 << 28,
    S_DONE    = 30'd1 << 29
  } state_e;

  // ---------------------------------------------------------------- memories
  // headers, physical predecessors, free links and list heads; one write and
  // one registered read per cycle each
  tlsf_pkg::hdr_t hdr_mem  [tlsf_pkg::Granules];
  logic [GW-1:0]  pred_mem [tlsf_pkg::Granules];
  logic [LW-1:0]  nxt_mem  [tlsf_pkg::Granules];
  logic [LW-1:0]  prv_mem  [tlsf_pkg::Granules];
  logic [LW-1:0]  head_mem [tlsf_pkg::ClassCount];

  logic           hdr_we, pred_we, nxt_we, prv_we, head_we;
  logic [GW-1:0]  hdr_wa, hdr_ra, pred_wa, pred_ra, nxt_wa, nxt_ra, prv_wa, prv_ra;
  logic [CW-1:0]  head_wa, head_ra;
  tlsf_pkg::hdr_t hdr_wd, hdr_rd;
  logic [GW-1:0]  pred_wd, pred_rd;
  logic [LW-1:0]  nxt_wd, nxt_rd, prv_wd, prv_rd, head_wd, head_rd;

  always_ff @(posedge clk_i) begin
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    hdr_rd <= hdr_mem[hdr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pred_we) pred_mem[pred_wa] <= pred_wd;
    pred_rd <= pred_mem[pred_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd <= nxt_mem[nxt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    prv_rd <= prv_mem[prv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end

  // ------------------------------------------------------------ shared units
  logic [16:0]                     cls_in;
  tlsf_pkg::cls_t                  cls;
  tlsf_pkg::bm_cmd_t               bm_cmd;
  logic [tlsf_pkg::FlW-1:0]        bm_rd_fl;
  logic [tlsf_pkg::L2Count-1:0]    bm_row;
  logic [tlsf_pkg::FlClasses-1:0]  bm_fl_map;

  tlsf_class u_class (
    .size_i (cls_in),
    .cls_o  (cls)
  );

  tlsf_bitmap u_bitmap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (bm_cmd),
    .rd_fl_i  (bm_rd_fl),
    .row_o    (bm_row),
    .fl_map_o (bm_fl_map)
  );

  // --------------------------------------------------------------- registers
  state_e        state_q, state_d, ret_q, ret_d;
  logic [GW-1:0] cnt_q, cnt_d;
  logic [16:0]   s_q, s_d, t_q, t_d;
  logic [tlsf_pkg::FlW-1:0] fl_q, fl_d;
  logic [GW-1:0] g_q, g_d, r_q, r_d, n_q, n_d, cur_q, cur_d, x_q, x_d;
  logic [15:0]   whole_q, whole_d, rs_q, rs_d, gsize_q, gsize_d;
  logic [15:0]   cursize_q, cursize_d, xsize_q, xsize_d;
  logic          gpf_q, gpf_d, curpf_q, curpf_d;
  logic [LW-1:0] h_q, h_d;
  logic          done_q, done_d;
  logic [1:0]    status_q, status_d;
  logic [15:0]   payload_q, payload_d;

  // ----------------------------------------------------------------- helpers
  logic [16:0]                  s_round;
  logic [GW-1:0]                g_free;
  logic                         off_ok;
  logic [tlsf_pkg::L2Count-1:0] m_sl;
  logic [tlsf_pkg::FlClasses-1:0] m_fl;
  logic [5:0]                   fl_next;
  logic [CW-1:0]                x_class;
  logic [17:0]                  split_need;
  tlsf_pkg::hdr_t               hdr_mod;

  always_comb begin
    // request rounded to a granule, at least one minimum block
    s_round = ({1'b0, request_size_i} + 17'(tlsf_pkg::GranuleBytes - 1))
              & ~17'(tlsf_pkg::GranuleBytes - 1);
    if (s_round < 17'(tlsf_pkg::MinBlock)) s_round = 17'(tlsf_pkg::MinBlock);
    off_ok  = (free_offset_i >= 16'(tlsf_pkg::HeaderBytes)) && (free_offset_i[2:0] == 3'd0);
    g_free  = GW'(free_offset_i[15:3] - 13'(tlsf_pkg::HdrGran));
    m_sl    = bm_row & ({tlsf_pkg::L2Count{1'b1}} << cls.sl);
    fl_next = {1'b0, cls.fl} + 6'd1;
    m_fl    = bm_fl_map & ({tlsf_pkg::FlClasses{1'b1}} << fl_next);
    x_class = {cls.fl, cls.sl};
    split_need = {1'b0, s_q} + 18'(tlsf_pkg::HeaderBytes + tlsf_pkg::MinBlock);
  end

  // --------------------------------------------------------------- sequencer
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cnt_d     = cnt_q;
    s_d       = s_q;
    t_d       = t_q;
    fl_d      = fl_q;
    g_d       = g_q;
    r_d       = r_q;
    n_d       = n_q;
    cur_d     = cur_q;
    x_d       = x_q;
    whole_d   = whole_q;
    rs_d      = rs_q;
    gsize_d   = gsize_q;
    cursize_d = cursize_q;
    xsize_d   = xsize_q;
    gpf_d     = gpf_q;
    curpf_d   = curpf_q;
    h_d       = h_q;
    done_d    = 1'b0;
    status_d  = status_q;
    payload_d = payload_q;

    hdr_we  = 1'b0; hdr_wa  = x_q; hdr_wd = '0; hdr_ra = x_q;
    pred_we = 1'b0; pred_wa = x_q; pred_wd = '0; pred_ra = x_q;
    nxt_we  = 1'b0; nxt_wa  = x_q; nxt_wd = '0; nxt_ra = x_q;
    prv_we  = 1'b0; prv_wa  = x_q; prv_wd = '0; prv_ra = x_q;
    head_we = 1'b0; head_wa = x_class; head_wd = '0; head_ra = x_class;

    cls_in   = {1'b0, xsize_q};
    bm_cmd   = '0;
    bm_cmd.fl = cls.fl;
    bm_cmd.sl = cls.sl;
    bm_rd_fl = cls.fl;
    hdr_mod  = hdr_rd;

    case (state_q)
      S_CLEAR: begin
        hdr_we = 1'b1;
        hdr_wa = cnt_q;
        hdr_wd = '0;
        if (cnt_q < GW'(tlsf_pkg::ClassCount)) begin
          head_we = 1'b1;
          head_wa = cnt_q[CW-1:0];
          head_wd = tlsf_pkg::Nil;
        end
        cnt_d = cnt_q + GW'(1);
        if (cnt_q == GW'(tlsf_pkg::Granules - 1)) state_d = S_INIT0;
      end
      S_INIT0: begin
        // one big free block after the start sentinel
        hdr_we  = 1'b1;
        hdr_wa  = GW'(tlsf_pkg::HdrGran);
        hdr_wd  = '{valid: 1'b1, free: 1'b1, pfree: 1'b0, size: 16'(tlsf_pkg::BigBytes)};
        pred_we = 1'b1;
        pred_wa = GW'(tlsf_pkg::HdrGran);
        pred_wd = '0;
        state_d = S_INIT1;
      end
      S_INIT1: begin
        hdr_we  = 1'b1;
        hdr_wa  = '0;
        hdr_wd  = '{valid: 1'b1, free: 1'b0, pfree: 1'b0, size: 16'd0};
        state_d = S_INIT2;
      end
      S_INIT2: begin
        hdr_we  = 1'b1;
        hdr_wa  = GW'(tlsf_pkg::TailGran);
        hdr_wd  = '{valid: 1'b1, free: 1'b0, pfree: 1'b1, size: 16'd0};
        pred_we = 1'b1;
        pred_wa = GW'(tlsf_pkg::TailGran);
        pred_wd = GW'(tlsf_pkg::HdrGran);
        x_d     = GW'(tlsf_pkg::HdrGran);
        xsize_d = 16'(tlsf_pkg::BigBytes);
        ret_d   = S_IDLE;
        state_d = S_L0;
      end
      S_IDLE: begin
        if (start_i) begin
          payload_d = '0;
          status_d  = tlsf_pkg::StOk;
          if (action_i == tlsf_pkg::ActAlloc) begin
            s_d = s_round;
            if (request_size_i == 16'd0) begin
              status_d = tlsf_pkg::StZero;
              state_d  = S_DONE;
            end else begin
              state_d = S_AROUND;
            end
          end else if (!off_ok) begin
            state_d = S_DONE;
          end else begin
            g_d     = g_free;
            hdr_ra  = g_free;
            state_d = S_FCHK;
          end
        end
      end

      // ------------------------------------------------------------ allocate
      S_AROUND: begin
        // round up to the next class boundary
        cls_in = s_q;
        if (s_q < 17'(tlsf_pkg::SmallLimit)) begin
          t_d = s_q;
        end else begin
          t_d = s_q + ((17'd1 << (cls.tb - 5'(tlsf_pkg::SlBits))) - 17'd1);
        end
        state_d = S_ACLASS;
      end
      S_ACLASS: begin
        cls_in   = t_q;
        bm_rd_fl = cls.fl;
        if (m_sl != '0) begin
          head_ra = {cls.fl, tlsf_pkg::low_bit16(m_sl)};
          state_d = S_AHEAD;
        end else if (m_fl == '0) begin
          status_d = tlsf_pkg::StNoFit;
          state_d  = S_DONE;
        end else begin
          fl_d    = tlsf_pkg::low_bit32(m_fl);
          state_d = S_ASRCH2;
        end
      end
      S_ASRCH2: begin
        bm_rd_fl = fl_q;
        if (bm_row == '0) begin
          status_d = tlsf_pkg::StNoFit;
          state_d  = S_DONE;
        end else begin
          head_ra = {fl_q, tlsf_pkg::low_bit16(bm_row)};
          state_d = S_AHEAD;
        end
      end
      S_AHEAD: begin
        if (head_rd == tlsf_pkg::Nil) begin
          status_d = tlsf_pkg::StNoFit;
          state_d  = S_DONE;
        end else begin
          g_d     = head_rd[GW-1:0];
          hdr_ra  = head_rd[GW-1:0];
          state_d = S_AHDR;
        end
      end
      S_AHDR: begin
        whole_d   = hdr_rd.size;
        gpf_d     = hdr_rd.pfree;
        n_d       = g_q + GW'(tlsf_pkg::HdrGran) + GW'(hdr_rd.size >> 3);
        payload_d = 16'({g_q, 3'b000}) + 16'(tlsf_pkg::HeaderBytes);
        x_d       = g_q;
        xsize_d   = hdr_rd.size;
        ret_d     = S_ASPLIT;
        state_d   = S_U0;
      end
      S_ASPLIT: begin
        hdr_ra = n_q;
        if ({2'b00, whole_q} >= split_need) begin
          r_d     = g_q + GW'(tlsf_pkg::HdrGran) + GW'(s_q >> 3);
          rs_d    = whole_q - s_q[15:0] - 16'(tlsf_pkg::HeaderBytes);
          hdr_we  = 1'b1;
          hdr_wa  = r_d;
          hdr_wd  = '{valid: 1'b1, free: 1'b1, pfree: 1'b0, size: rs_d};
          pred_we = 1'b1;
          pred_wa = r_d;
          pred_wd = g_q;
          state_d = S_AS1;
        end else begin
          hdr_we  = 1'b1;
          hdr_wa  = g_q;
          hdr_wd  = '{valid: 1'b1, free: 1'b0, pfree: gpf_q, size: whole_q};
          state_d = S_AN1;
        end
      end
      S_AS1: begin
        // block after the remainder sees a free predecessor
        hdr_mod.pfree = 1'b1;
        hdr_we  = 1'b1;
        hdr_wa  = n_q;
        hdr_wd  = hdr_mod;
        pred_we = 1'b1;
        pred_wa = n_q;
        pred_wd = r_q;
        state_d = S_AS2;
      end
      S_AS2: begin
        hdr_we  = 1'b1;
        hdr_wa  = g_q;
        hdr_wd  = '{valid: 1'b1, free: 1'b0, pfree: gpf_q, size: s_q[15:0]};
        x_d     = r_q;
        xsize_d = rs_q;
        ret_d   = S_DONE;
        state_d = S_L0;
      end
      S_AN1: begin
        hdr_mod.pfree = 1'b0;
        hdr_we  = 1'b1;
        hdr_wa  = n_q;
        hdr_wd  = hdr_mod;
        state_d = S_DONE;
      end

      // ---------------------------------------------------------------- free
      S_FCHK: begin
        if (!hdr_rd.valid || (hdr_rd.size == 16'd0) || hdr_rd.free) begin
          state_d = S_DONE;     // not a live in-use block: ignored
        end else begin
          gsize_d = hdr_rd.size;
          if (hdr_rd.pfree) begin
            pred_ra = g_q;
            state_d = S_FP0;
          end else begin
            hdr_we    = 1'b1;
            hdr_wa    = g_q;
            hdr_wd    = '{valid: 1'b1, free: 1'b1, pfree: 1'b0, size: hdr_rd.size};
            cur_d     = g_q;
            cursize_d = hdr_rd.size;
            curpf_d   = 1'b0;
            state_d   = S_FNXT;
          end
        end
      end
      S_FP0: begin
        hdr_ra  = pred_rd;
        x_d     = pred_rd;
        state_d = S_FP1;
      end
      S_FP1: begin
        cur_d     = x_q;
        curpf_d   = hdr_rd.pfree;
        xsize_d   = hdr_rd.size;
        cursize_d = hdr_rd.size + gsize_q + 16'(tlsf_pkg::HeaderBytes);
        ret_d     = S_FP2;
        state_d   = S_U0;
      end
      S_FP2: begin
        hdr_we  = 1'b1;
        hdr_wa  = cur_q;
        hdr_wd  = '{valid: 1'b1, free: 1'b1, pfree: curpf_q, size: cursize_q};
        state_d = S_FP3;
      end
      S_FP3: begin
        hdr_we  = 1'b1;
        hdr_wa  = g_q;
        hdr_wd  = '0;
        state_d = S_FNXT;
      end
      S_FNXT: begin
        n_d     = cur_q + GW'(tlsf_pkg::HdrGran) + GW'(cursize_q >> 3);
        hdr_ra  = n_d;
        state_d = S_FN1;
      end
      S_FN1: begin
        if (hdr_rd.free) begin
          x_d       = n_q;
          xsize_d   = hdr_rd.size;
          cursize_d = cursize_q + hdr_rd.size + 16'(tlsf_pkg::HeaderBytes);
          ret_d     = S_FN2;
          state_d   = S_U0;
        end else begin
          hdr_mod.pfree = 1'b1;
          hdr_we  = 1'b1;
          hdr_wa  = n_q;
          hdr_wd  = hdr_mod;
          pred_we = 1'b1;
          pred_wa = n_q;
          pred_wd = cur_q;
          x_d     = cur_q;
          xsize_d = cursize_q;
          ret_d   = S_DONE;
          state_d = S_L0;
        end
      end
      S_FN2: begin
        hdr_we  = 1'b1;
        hdr_wa  = cur_q;
        hdr_wd  = '{valid: 1'b1, free: 1'b1, pfree: curpf_q, size: cursize_q};
        state_d = S_FN3;
      end
      S_FN3: begin
        hdr_we  = 1'b1;
        hdr_wa  = n_q;
        hdr_wd  = '0;
        n_d     = cur_q + GW'(tlsf_pkg::HdrGran) + GW'(cursize_q >> 3);
        hdr_ra  = n_d;
        state_d = S_FN4;
      end
      S_FN4: begin
        hdr_mod.pfree = 1'b1;
        hdr_we  = 1'b1;
        hdr_wa  = n_q;
        hdr_wd  = hdr_mod;
        pred_we = 1'b1;
        pred_wa = n_q;
        pred_wd = cur_q;
        x_d     = cur_q;
        xsize_d = cursize_q;
        ret_d   = S_DONE;
        state_d = S_L0;
      end

      // ------------------------------------------------ unlink block x_q
      S_U0: begin
        prv_ra  = x_q;
        nxt_ra  = x_q;
        state_d = S_U1;
      end
      S_U1: begin
        if (nxt_rd != tlsf_pkg::Nil) begin
          prv_we = 1'b1;
          prv_wa = nxt_rd[GW-1:0];
          prv_wd = prv_rd;
        end
        if (prv_rd != tlsf_pkg::Nil) begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd[GW-1:0];
          nxt_wd = nxt_rd;
        end else begin
          head_we = 1'b1;
          head_wa = x_class;
          head_wd = nxt_rd;
          bm_cmd.clr = (nxt_rd == tlsf_pkg::Nil);
        end
        state_d = ret_q;
      end

      // -------------------------------------------- link block x_q at head
      S_L0: begin
        head_ra = x_class;
        state_d = S_L1;
      end
      S_L1: begin
        h_d     = head_rd;
        nxt_we  = 1'b1;
        nxt_wa  = x_q;
        nxt_wd  = head_rd;
        prv_we  = 1'b1;
        prv_wa  = x_q;
        prv_wd  = tlsf_pkg::Nil;
        head_we = 1'b1;
        head_wa = x_class;
        head_wd = LW'(x_q);
        bm_cmd.set = 1'b1;
        state_d = S_L2;
      end
      S_L2: begin
        if (h_q != tlsf_pkg::Nil) begin
          prv_we = 1'b1;
          prv_wa = h_q[GW-1:0];
          prv_wd = LW'(x_q);
        end
        state_d = ret_q;
      end

      S_DONE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q       <= s_d;
    t_q       <= t_d;
    fl_q      <= fl_d;
    g_q       <= g_d;
    r_q       <= r_d;
    n_q       <= n_d;
    cur_q     <= cur_d;
    x_q       <= x_d;
    whole_q   <= whole_d;
    rs_q      <= rs_d;
    gsize_q   <= gsize_d;
    cursize_q <= cursize_d;
    xsize_q   <= xsize_d;
    gpf_q     <= gpf_d;
    curpf_q   <= curpf_d;
    h_q       <= h_d;
    status_q  <= status_d;
    payload_q <= payload_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign payload_offset_o = payload_q;
  assign status_o         = status_q;

endmodule

### design/tlsf_class.sv
// Size class mapper: first-level and second-level class of a size.
// Depends on tlsf_pkg.
module tlsf_class (
  input  logic [16:0]         size_i,
  output tlsf_pkg::cls_t      cls_o
);

  logic [4:0]  tb;
  logic [16:0] sh;

  always_comb begin
    tb = tlsf_pkg::top_bit17(size_i);
    sh = size_i >> (tb - 5'(tlsf_pkg::SlBits));
    cls_o.tb = tb;
    if (size_i < 17'(tlsf_pkg::SmallLimit)) begin
      // small sizes share class 0 in steps of 8
      cls_o.fl = '0;
      cls_o.sl = size_i[6:3];
    end else begin
      cls_o.fl = tb[tlsf_pkg::FlW-1:0];
      cls_o.sl = sh[tlsf_pkg::SlBits-1:0];
    end
  end

endmodule

### design/tlsf_bitmap.sv
// First-level and second-level occupancy bitmaps with set and clear commands.
// Depends on tlsf_pkg.
module tlsf_bitmap (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tlsf_pkg::bm_cmd_t                   cmd_i,
  input  logic [tlsf_pkg::FlW-1:0]            rd_fl_i,
  output logic [tlsf_pkg::L2Count-1:0]        row_o,
  output logic [tlsf_pkg::FlClasses-1:0]      fl_map_o
);

  logic [tlsf_pkg::L2Count-1:0]   sl_map_q [tlsf_pkg::FlClasses];
  logic [tlsf_pkg::FlClasses-1:0] fl_map_q;
  logic [tlsf_pkg::FlW-1:0]       idx;
  logic [tlsf_pkg::L2Count-1:0]   bit_sel;
  logic [tlsf_pkg::L2Count-1:0]   cleared;

  always_comb begin
    idx     = (cmd_i.set || cmd_i.clr) ? cmd_i.fl : rd_fl_i;
    row_o   = sl_map_q[idx];
    bit_sel = tlsf_pkg::L2Count'(1) << cmd_i.sl;
    cleared = row_o & ~bit_sel;
  end

  assign fl_map_o = fl_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_map_q <= '0;
      for (int i = 0; i < tlsf_pkg::FlClasses; i++) sl_map_q[i] <= '0;
    end else if (cmd_i.set) begin
      sl_map_q[cmd_i.fl] <= row_o | bit_sel;
      fl_map_q[cmd_i.fl] <= 1'b1;
    end else if (cmd_i.clr) begin
      sl_map_q[cmd_i.fl] <= cleared;
      if (cleared == '0) fl_map_q[cmd_i.fl] <= 1'b0;
    end
  end

endmodule

### dv/two_level_segregated_fit_allocator_test.sv
// Testbench of the two-level segregated fit allocator: directed and random
// allocate/free requests, each result checked against an in-bench pool predictor.
// Depends on tlsf_pkg and two_level_segregated_fit_allocator.
`timescale 1ns / 100ps

module two_level_segregated_fit_allocator_test;

  localparam int unsigned PoolBytes    = tlsf_pkg::PoolBytes;
  localparam int unsigned GranuleBytes = tlsf_pkg::GranuleBytes;
  localparam int unsigned HeaderBytes  = tlsf_pkg::HeaderBytes;
  localparam int unsigned MinBlock     = tlsf_pkg::MinBlock;
  localparam int unsigned SlBits       = tlsf_pkg::SlBits;
  localparam int unsigned FlClasses    = tlsf_pkg::FlClasses;
  localparam int unsigned SmallLimit   = tlsf_pkg::SmallLimit;
  localparam int unsigned Granules     = tlsf_pkg::Granules;
  localparam int unsigned L2Count      = tlsf_pkg::L2Count;
  localparam int unsigned ClassCount   = tlsf_pkg::ClassCount;
  localparam int unsigned HdrGran      = tlsf_pkg::HdrGran;
  localparam int unsigned BigBytes     = tlsf_pkg::BigBytes;

  localparam logic ActAlloc = tlsf_pkg::ActAlloc;
  localparam logic ActFree  = tlsf_pkg::ActFree;
  localparam logic [1:0] StDone   = tlsf_pkg::StOk;
  localparam logic [1:0] StNoFit  = tlsf_pkg::StNoFit;
  localparam logic [1:0] StZero   = tlsf_pkg::StZero;
  localparam int unsigned FreeBit  = 1;
  localparam int unsigned PfreeBit = 2;
  localparam int unsigned SizeMask = ~32'd3;
  localparam int unsigned SmallStep = SmallLimit >> SlBits;
  localparam int unsigned NilG = Granules;
  localparam int WatchLimit = 50000;   // covers the clearing pass after reset

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        action_i = 1'b0;
  logic [15:0] request_size_i = '0;
  logic [15:0] free_offset_i = '0;
  logic        busy_o, done_o;
  logic [15:0] payload_offset_o;
  logic [1:0]  status_o;

  two_level_segregated_fit_allocator i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .request_size_i,
    .free_offset_i, .done_o, .payload_offset_o, .status_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  typedef struct packed {
    logic [15:0] offset;
    logic [1:0]  status;
  } alloc_result_t;

  alloc_result_t pending_results[$];
  logic [15:0]   live_blocks[$];     // payload offsets currently in use
  logic [15:0]   freed_blocks[$];    // recently freed, for double-free requests
  int mismatches = 0;
  int idle_cycles = 0;

  // ---------------- pool predictor ----------------
  int unsigned hdr_word[Granules];
  int unsigned pred_link[Granules];
  int unsigned next_link[Granules];
  int unsigned prev_link[Granules];
  bit          hdr_live[Granules];
  int unsigned fl_map;
  int unsigned sl_map[FlClasses];
  int unsigned list_head[ClassCount];

  function automatic int unsigned clamp_g(int unsigned g);
    return g < Granules ? g : Granules - 1;
  endfunction

  function automatic int unsigned msb_of(int unsigned w);
    int unsigned r;
    r = 0;
    while (w > 1) begin
      w = w >> 1;
      r++;
    end
    return r;
  endfunction

  function automatic int unsigned lsb_of(longint unsigned w);
    int unsigned r;
    r = 0;
    if (w == 0) return 0;
    while (!w[0]) begin
      w = w >> 1;
      r++;
    end
    return r;
  endfunction

  function automatic int unsigned blk_bytes(int unsigned g);
    return hdr_word[clamp_g(g)] & SizeMask;
  endfunction

  function automatic int unsigned next_phys(int unsigned g);
    return clamp_g(g + HdrGran + blk_bytes(g) / GranuleBytes);
  endfunction

  function automatic void size_class(int unsigned s, output int unsigned fl,
                                     output int unsigned sl);
    int unsigned f;
    if (s < SmallLimit) begin
      fl = 0;
      sl = s / SmallStep;
    end else begin
      f = msb_of(s);
      fl = f;
      sl = (s >> (f - SlBits)) - L2Count;
    end
  endfunction

  // oversized blocks fall into the top class
  function automatic int unsigned block_list(int unsigned g, output int unsigned fl,
                                             output int unsigned sl);
    size_class(blk_bytes(g), fl, sl);
    if (fl >= FlClasses) begin
      fl = FlClasses - 1;
      sl = L2Count - 1;
    end
    return fl * L2Count + sl;
  endfunction

  function automatic void list_remove(int unsigned g);
    int unsigned fl, sl, c, p, n;
    c = block_list(g, fl, sl);
    p = prev_link[clamp_g(g)];
    n = next_link[clamp_g(g)];
    if (n != NilG) prev_link[clamp_g(n)] = p;
    if (p != NilG) begin
      next_link[clamp_g(p)] = n;
    end else begin
      list_head[c] = n;
      if (n == NilG) begin
        sl_map[fl] &= ~(32'd1 << sl);
        if (sl_map[fl] == 0) fl_map &= ~(32'd1 << fl);
      end
    end
  endfunction

  function automatic void list_insert(int unsigned g);
    int unsigned fl, sl, c, h;
    c = block_list(g, fl, sl);
    h = list_head[c];
    next_link[clamp_g(g)] = h;
    prev_link[clamp_g(g)] = NilG;
    if (h != NilG) prev_link[clamp_g(h)] = g;
    list_head[c] = g;
    fl_map |= 32'd1 << fl;
    sl_map[fl] |= 32'd1 << sl;
  endfunction

  function automatic void pool_reset();
    int unsigned bg, tg;
    for (int i = 0; i < Granules; i++) begin
      hdr_word[i] = 0; pred_link[i] = 0; next_link[i] = 0; prev_link[i] = 0;
      hdr_live[i] = 0;
    end
    for (int i = 0; i < FlClasses; i++) sl_map[i] = 0;
    for (int i = 0; i < ClassCount; i++) list_head[i] = NilG;
    fl_map = 0;
    bg = HdrGran;
    tg = clamp_g(bg + HdrGran + BigBytes / GranuleBytes);
    hdr_live[0] = 1;
    hdr_word[bg] = BigBytes | FreeBit;
    pred_link[bg] = 0;
    hdr_live[bg] = 1;
    hdr_word[tg] = PfreeBit;
    pred_link[tg] = bg;
    hdr_live[tg] = 1;
    list_insert(bg);
  endfunction

  function automatic logic [1:0] pool_alloc(int unsigned req, output logic [15:0] off);
    int unsigned s, t, fl, sl, g, whole, n, r;
    longint unsigned m, fm;
    off = '0;
    if (req == 0) return StZero;
    s = ((req + GranuleBytes - 1) / GranuleBytes) * GranuleBytes;
    if (s < MinBlock) s = MinBlock;
    t = s;
    if (t < SmallLimit) t = ((t + SmallStep - 1) / SmallStep) * SmallStep;
    if (t >= SmallLimit) t += (32'd1 << (msb_of(t) - SlBits)) - 1;
    size_class(t, fl, sl);
    if (fl >= FlClasses) return StNoFit;
    m = longint'(sl_map[fl]) & (~64'd0 << sl);
    if (m == 0) begin
      fm = longint'(fl_map) & (~64'd0 << (fl + 1));
      if (fm == 0) return StNoFit;
      fl = lsb_of(fm);
      if (fl >= FlClasses) return StNoFit;
      m = sl_map[fl];
      if (m == 0) return StNoFit;
    end
    sl = lsb_of(m);
    g = list_head[fl * L2Count + sl];
    if (g >= Granules) return StNoFit;
    list_remove(g);
    whole = blk_bytes(g);
    // split: remainder keeps a header and a minimum payload
    if (whole >= s + HeaderBytes + MinBlock) begin
      r = clamp_g(g + HdrGran + s / GranuleBytes);
      hdr_word[r] = (whole - s - HeaderBytes) | FreeBit;
      pred_link[r] = g;
      hdr_live[r] = 1;
      hdr_word[g] = s | (hdr_word[g] & PfreeBit);
      n = next_phys(r);
      hdr_word[n] |= PfreeBit;
      pred_link[n] = r;
      list_insert(r);
    end
    hdr_word[g] &= ~FreeBit;
    n = next_phys(g);
    hdr_word[n] &= ~PfreeBit;
    off = 16'(g * GranuleBytes + HeaderBytes);
    return StDone;
  endfunction

  function automatic void pool_free(int unsigned off);
    int unsigned g, n, p;
    if (off < HeaderBytes || (off - HeaderBytes) % GranuleBytes != 0) return;
    g = (off - HeaderBytes) / GranuleBytes;
    if (g >= Granules || !hdr_live[g] || blk_bytes(g) == 0) return;
    if (hdr_word[g] & FreeBit) return;   // double free
    hdr_word[g] |= FreeBit;
    if (hdr_word[g] & PfreeBit) begin
      p = clamp_g(pred_link[g]);
      list_remove(p);
      hdr_word[p] += blk_bytes(g) + HeaderBytes;
      hdr_live[g] = 0;
      g = p;
    end
    n = next_phys(g);
    if (hdr_word[n] & FreeBit) begin
      list_remove(n);
      hdr_word[g] += blk_bytes(n) + HeaderBytes;
      hdr_live[n] = 0;
      n = next_phys(g);
    end
    hdr_word[n] |= PfreeBit;
    pred_link[n] = g;
    list_insert(g);
  endfunction

  // ---------------- request driver ----------------
  task automatic send_request(logic act, logic [15:0] size, logic [15:0] off);
    int gap;
    alloc_result_t res;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= act;
    request_size_i <= size;
    free_offset_i <= off;
    do @(posedge clk_i); while (busy_o);
    res.offset = '0;
    res.status = StDone;
    if (act == ActFree) begin
      pool_free(off);
      for (int i = 0; i < live_blocks.size(); i++) begin
        if (live_blocks[i] == off) begin
          live_blocks.delete(i);
          freed_blocks.push_back(off);
          if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
          break;
        end
      end
    end else begin
      res.status = pool_alloc(size, res.offset);
      if (res.status == StDone) live_blocks.push_back(res.offset);
    end
    pending_results.push_back(res);
  endtask

  task automatic free_live(int idx);
    send_request(ActFree, 16'($urandom), live_blocks[idx]);
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    alloc_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: offset %0d status %0d",
                                       payload_offset_o, status_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (payload_offset_o !== exp_r.offset || status_o !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected offset %0d status %0d, got offset %0d status %0d",
                     exp_r.offset, exp_r.status, payload_offset_o, status_o);
        end
      end
    end
  end

  // watchdog: cycles with neither an accepted request nor a result
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_rejects();
    send_request(ActAlloc, 16'd0, 16'hFFFF);      // zero size
    send_request(ActAlloc, 16'hFFFF, 16'd0);      // class beyond the pool
    send_request(ActFree, 16'hFFFF, 16'd0);       // start sentinel
    send_request(ActFree, 16'd0, 16'd37);         // misaligned
    send_request(ActFree, 16'd5, 16'hFFFF);       // far end
    send_request(ActFree, 16'd5, 16'd64);         // free block, not in use
  endtask

  task automatic test_split_and_merge();
    logic [15:0] a, b, c;
    send_request(ActAlloc, 16'd1, 16'd0);         // minimum block
    send_request(ActAlloc, 16'd100, 16'd0);
    send_request(ActAlloc, 16'd33, 16'd0);
    send_request(ActAlloc, 16'd4000, 16'd0);
    a = live_blocks[0]; b = live_blocks[1]; c = live_blocks[2];
    send_request(ActFree, 16'd0, a);
    send_request(ActFree, 16'd0, c);
    send_request(ActFree, 16'd0, b);              // merges both neighbors
    send_request(ActFree, 16'd0, b);              // double free
    while (live_blocks.size() > 0) free_live(0);
  endtask

  task automatic test_exhaust();
    send_request(ActAlloc, 16'(BigBytes), 16'd0); // class rounds past the big block
    send_request(ActAlloc, 16'd8, 16'd0);         // minimum block
    while (live_blocks.size() > 0) free_live(0);
    send_request(ActAlloc, 16'd32768, 16'd0);
    send_request(ActAlloc, 16'd30000, 16'd0);
    send_request(ActAlloc, 16'd20000, 16'd0);
    while (live_blocks.size() > 0) free_live(live_blocks.size() - 1);
  endtask

  task automatic test_random(int count);
    int pick;
    logic [15:0] size;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (live_blocks.size() > 60) pick = 60 + pick % 40;
      if (pick < 55) begin
        case ($urandom_range(0, 9))
          0:       size = 16'($urandom);
          1, 2:    size = 16'($urandom_range(0, 4096));
          3:       size = 16'($urandom_range(0, 3));
          default: size = 16'($urandom_range(1, 256));
        endcase
        send_request(ActAlloc, size, 16'($urandom));
      end else if (pick < 90 && live_blocks.size() > 0) begin
        free_live($urandom_range(0, live_blocks.size() - 1));
      end else if (pick < 95 && freed_blocks.size() > 0) begin
        send_request(ActFree, 16'($urandom),
                     freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
      end else begin
        send_request(ActFree, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    pool_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_rejects();
    test_split_and_merge();
    test_exhaust();
    test_random(1550);
    while (live_blocks.size() > 0) free_live(0);
    @(posedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
